### design/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared constants, types and the byte-wise CRC function of the
// remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   // Frame geometry. A frame is FRAME_BYTES long (12 to 64).
   localparam int FRAME_BYTES   = 21;
   localparam int POS_W         = $clog2(FRAME_BYTES + 1);
   localparam int PAYLOAD_FIRST = 2;
   localparam int PAYLOAD_BYTES = 8;
   localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
   localparam int LANE_W        = $clog2(PAYLOAD_BYTES);

   // CRC-16, reflected form.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // Channel geometry.
   localparam int RAW_W = 11;
   localparam int CHN_W = 12;

   // Queue between the byte front end and the decode back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER      = 2'd2;

   localparam logic [7:0]       FIRST_SYNC_RESET  = 8'd169;
   localparam logic [7:0]       SECOND_SYNC_RESET = 8'd83;
   localparam logic [RAW_W-1:0] CENTER_RESET      = 11'd1024;

   // One completed frame handed from the front end to the back end.
   typedef struct packed {
      logic                 ok;
      logic [PAYLOAD_W-1:0] payload;
   } frame_rec_type;

   // Queue status as seen by the producer and the consumer.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### design/rcfd_front.sv
// ----------------------------------------------------------------------------
// rcfd_front
// Byte front end: tracks the frame position, runs the CRC, checks the sync
// bytes, gathers the payload and hands each finished frame to the queue.
// ----------------------------------------------------------------------------
module rcfd_front
   import rcfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_take,
   input  logic [7:0]       rx_byte,
   input  logic             buffer_start,
   input  logic [7:0]       first_sync,
   input  logic [7:0]       second_sync,
   output logic             push,
   output frame_rec_type    push_rec
);

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 sync_ff, sync_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [7:0]           crc_low_ff, crc_low_in;

   logic [POS_W-1:0] eff_pos;
   logic [15:0]      eff_crc;
   logic             eff_sync;
   logic             active;
   logic [POS_W-1:0] lane_off;
   logic [LANE_W-1:0] lane;

   // A start flag restarts the frame with this byte, dropping any partial one.
   assign eff_pos  = buffer_start ? '0 : pos_ff;
   assign eff_crc  = buffer_start ? CRC_INIT : crc_ff;
   assign eff_sync = buffer_start ? 1'b0 : sync_ff;
   assign active   = (eff_pos < POS_W'(FRAME_BYTES));
   assign lane_off = eff_pos - POS_W'(PAYLOAD_FIRST);
   assign lane     = lane_off[LANE_W-1:0];

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      sync_in    = sync_ff;
      payload_in = payload_ff;
      crc_low_in = crc_low_ff;
      push       = 1'b0;
      push_rec.ok      = 1'b0;
      push_rec.payload = payload_ff;
      if (byte_take && active) begin
         pos_in = eff_pos + POS_W'(1);
         if (eff_pos < POS_W'(FRAME_BYTES - 2)) begin
            crc_in = crc_byte(eff_crc, rx_byte);
         end else begin
            crc_in = eff_crc;
         end
         if (eff_pos == '0) begin
            sync_in = (rx_byte == first_sync);
         end else if (eff_pos == POS_W'(1)) begin
            sync_in = eff_sync && (rx_byte == second_sync);
         end else begin
            sync_in = eff_sync;
         end
         if (eff_pos >= POS_W'(PAYLOAD_FIRST) &&
             eff_pos < POS_W'(PAYLOAD_FIRST + PAYLOAD_BYTES)) begin
            payload_in[8*lane +: 8] = rx_byte;
         end
         if (eff_pos == POS_W'(FRAME_BYTES - 2)) begin
            crc_low_in = rx_byte;
         end
         if (eff_pos == POS_W'(FRAME_BYTES - 1)) begin
            push        = 1'b1;
            push_rec.ok = eff_sync && (crc_low_ff == eff_crc[7:0]) &&
                          (rx_byte == eff_crc[15:8]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_W'(FRAME_BYTES);
         crc_ff  <= CRC_INIT;
         sync_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         sync_ff <= sync_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      crc_low_ff <= crc_low_in;
   end

endmodule

### design/rcfd_queue.sv
// ----------------------------------------------------------------------------
// rcfd_queue
// Short first-in first-out queue of finished frame records between the
// front end and the back end.
// ----------------------------------------------------------------------------
module rcfd_queue
   import rcfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frame_rec_type    push_rec,
   input  logic             pop,
   output frame_rec_type    head_rec,
   output queue_status_type status
);

   frame_rec_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head_rec         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

### design/rcfd_back.sv
// ----------------------------------------------------------------------------
// rcfd_back
// Decode back end: unpacks a frame record into centered channels and button
// fields, keeps the button history and toggle flags, and holds the response
// in an output register.
// ----------------------------------------------------------------------------
module rcfd_back
   import rcfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  queue_status_type        q_status,
   input  frame_rec_type           head_rec,
   output logic                    pop,
   input  logic [RAW_W-1:0]        center,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_frame_ok,
   output logic signed [CHN_W-1:0] rsp_right_stick_h,
   output logic signed [CHN_W-1:0] rsp_right_stick_v,
   output logic signed [CHN_W-1:0] rsp_left_stick_v,
   output logic signed [CHN_W-1:0] rsp_left_stick_h,
   output logic [1:0]              rsp_mode_sel,
   output logic signed [CHN_W-1:0] rsp_dial_value,
   output logic [3:0]              rsp_button_levels,
   output logic [3:0]              rsp_button_edges,
   output logic [3:0]              rsp_toggle_flags
);

   function automatic logic [CHN_W-1:0] centred(input logic [RAW_W-1:0] raw,
                                                input logic [RAW_W-1:0] ctr);
      return {1'b0, raw} - {1'b0, ctr};
   endfunction

   logic                    valid_ff, valid_in;
   logic                    ok_ff, ok_in;
   logic signed [CHN_W-1:0] rsh_ff, rsh_in, rsv_ff, rsv_in;
   logic signed [CHN_W-1:0] lsv_ff, lsv_in, lsh_ff, lsh_in;
   logic signed [CHN_W-1:0] dial_ff, dial_in;
   logic [1:0]              mode_ff, mode_in;
   logic [3:0]              levels_ff, levels_in, edges_ff, edges_in;
   logic [3:0]              flags_ff, flags_in;
   logic [3:0]              prev_btn_ff, prev_btn_in;
   logic [3:0]              toggle_ff, toggle_in;

   logic [PAYLOAD_W-1:0] p;
   logic [3:0]           lv, eg;

   // The output register is refilled as soon as it is empty or being taken.
   assign pop = q_status.not_empty && (!valid_ff || rsp_ready);
   assign p   = head_rec.payload;
   assign lv  = {p[60], p[48], p[47], p[46]};
   assign eg  = lv & ~prev_btn_ff;

   always_comb begin
      valid_in    = valid_ff;
      prev_btn_in = prev_btn_ff;
      toggle_in   = toggle_ff;
      ok_in       = ok_ff;
      rsh_in      = rsh_ff;
      rsv_in      = rsv_ff;
      lsv_in      = lsv_ff;
      lsh_in      = lsh_ff;
      mode_in     = mode_ff;
      dial_in     = dial_ff;
      levels_in   = levels_ff;
      edges_in    = edges_ff;
      flags_in    = flags_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
         ok_in    = head_rec.ok;
         if (head_rec.ok) begin
            rsh_in      = centred(p[10:0], center);
            rsv_in      = centred(p[21:11], center);
            lsv_in      = centred(p[32:22], center);
            lsh_in      = centred(p[43:33], center);
            mode_in     = p[45:44];
            dial_in     = centred(p[59:49], center);
            levels_in   = lv;
            edges_in    = eg;
            flags_in    = toggle_ff ^ eg;
            toggle_in   = toggle_ff ^ eg;
            prev_btn_in = lv;
         end else begin
            rsh_in    = '0;
            rsv_in    = '0;
            lsv_in    = '0;
            lsh_in    = '0;
            mode_in   = '0;
            dial_in   = '0;
            levels_in = '0;
            edges_in  = '0;
            flags_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         prev_btn_ff <= '0;
         toggle_ff   <= '0;
      end else begin
         valid_ff    <= valid_in;
         prev_btn_ff <= prev_btn_in;
         toggle_ff   <= toggle_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff     <= ok_in;
      rsh_ff    <= rsh_in;
      rsv_ff    <= rsv_in;
      lsv_ff    <= lsv_in;
      lsh_ff    <= lsh_in;
      mode_ff   <= mode_in;
      dial_ff   <= dial_in;
      levels_ff <= levels_in;
      edges_ff  <= edges_in;
      flags_ff  <= flags_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_ok      = ok_ff;
   assign rsp_right_stick_h = rsh_ff;
   assign rsp_right_stick_v = rsv_ff;
   assign rsp_left_stick_v  = lsv_ff;
   assign rsp_left_stick_h  = lsh_ff;
   assign rsp_mode_sel      = mode_ff;
   assign rsp_dial_value    = dial_ff;
   assign rsp_button_levels = levels_ff;
   assign rsp_button_edges  = edges_ff;
   assign rsp_toggle_flags  = flags_ff;

endmodule

### design/rc_frame_crc_decoder.sv
// ----------------------------------------------------------------------------
// rc_frame_crc_decoder
// Remote-control frame receiver with sync and CRC-16 check and channel decode.
// ----------------------------------------------------------------------------
// Bytes are taken one per clock cycle while req_ready is high. A byte with
// req_buffer_start high opens a frame; each complete frame yields one
// response, with frame_ok low and all other fields zero when the sync bytes or
// the reflected CRC-16 do not match. The byte front end and the decode back
// end are joined by a two-entry frame queue, so req_ready drops only when that
// queue is full, which needs the response side to hold off while at least two
// more frames complete after the one waiting at the output. The user must
// write configuration through csr_we/csr_index/csr_wdata only while idle; the
// block itself does not enforce this.
module rc_frame_crc_decoder
   import rcfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   input  logic                    req_buffer_start,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_frame_ok,
   output logic signed [CHN_W-1:0] rsp_right_stick_h,
   output logic signed [CHN_W-1:0] rsp_right_stick_v,
   output logic signed [CHN_W-1:0] rsp_left_stick_v,
   output logic signed [CHN_W-1:0] rsp_left_stick_h,
   output logic [1:0]              rsp_mode_sel,
   output logic signed [CHN_W-1:0] rsp_dial_value,
   output logic [3:0]              rsp_button_levels,
   output logic [3:0]              rsp_button_edges,
   output logic [3:0]              rsp_toggle_flags,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [7:0]       first_sync_ff, second_sync_ff;
   logic [RAW_W-1:0] center_ff;

   logic             byte_take;
   logic             push, pop;
   frame_rec_type    push_rec, head_rec;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= FIRST_SYNC_RESET;
         second_sync_ff <= SECOND_SYNC_RESET;
         center_ff      <= CENTER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_SYNC:  first_sync_ff  <= csr_wdata[7:0];
            CSR_SECOND_SYNC: second_sync_ff <= csr_wdata[7:0];
            CSR_CENTER:      center_ff      <= csr_wdata[RAW_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !q_status.full;
   assign byte_take = req_valid && req_ready;

   rcfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (byte_take),
      .rx_byte      (req_rx_byte),
      .buffer_start (req_buffer_start),
      .first_sync   (first_sync_ff),
      .second_sync  (second_sync_ff),
      .push         (push),
      .push_rec     (push_rec)
   );

   rcfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   rcfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .head_rec          (head_rec),
      .pop               (pop),
      .center            (center_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_ok      (rsp_frame_ok),
      .rsp_right_stick_h (rsp_right_stick_h),
      .rsp_right_stick_v (rsp_right_stick_v),
      .rsp_left_stick_v  (rsp_left_stick_v),
      .rsp_left_stick_h  (rsp_left_stick_h),
      .rsp_mode_sel      (rsp_mode_sel),
      .rsp_dial_value    (rsp_dial_value),
      .rsp_button_levels (rsp_button_levels),
      .rsp_button_edges  (rsp_button_edges),
      .rsp_toggle_flags  (rsp_toggle_flags)
   );

endmodule

### design/rcfd_checker.sv
// ----------------------------------------------------------------------------
// rcfd_checker
// Port-level checks of the frame decoder's response channel.
// ----------------------------------------------------------------------------
module rcfd_checker
   import rcfd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_frame_ok,
   input logic signed [CHN_W-1:0] rsp_right_stick_h,
   input logic signed [CHN_W-1:0] rsp_right_stick_v,
   input logic signed [CHN_W-1:0] rsp_left_stick_v,
   input logic signed [CHN_W-1:0] rsp_left_stick_h,
   input logic [1:0]              rsp_mode_sel,
   input logic signed [CHN_W-1:0] rsp_dial_value,
   input logic [3:0]              rsp_button_levels,
   input logic [3:0]              rsp_button_edges,
   input logic [3:0]              rsp_toggle_flags
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_ok) &&
      $stable(rsp_right_stick_h) && $stable(rsp_dial_value) &&
      $stable(rsp_toggle_flags))
      else $error("response changed while stalled");

   // A rejected frame reports nothing but its failure.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |-> rsp_right_stick_h == '0 &&
      rsp_right_stick_v == '0 && rsp_left_stick_v == '0 && rsp_left_stick_h == '0 &&
      rsp_mode_sel == '0 && rsp_dial_value == '0 && rsp_button_levels == '0 &&
      rsp_button_edges == '0 && rsp_toggle_flags == '0)
      else $error("bad frame carries nonzero fields");

   // A button can only have risen if it is pressed now.
   a_edge_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_button_edges & ~rsp_button_levels) == 4'b0000)
      else $error("button edge without button level");

   // Reset empties the output register.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind rc_frame_crc_decoder rcfd_checker u_rcfd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_frame_ok      (rsp_frame_ok),
   .rsp_right_stick_h (rsp_right_stick_h),
   .rsp_right_stick_v (rsp_right_stick_v),
   .rsp_left_stick_v  (rsp_left_stick_v),
   .rsp_left_stick_h  (rsp_left_stick_h),
   .rsp_mode_sel      (rsp_mode_sel),
   .rsp_dial_value    (rsp_dial_value),
   .rsp_button_levels (rsp_button_levels),
   .rsp_button_edges  (rsp_button_edges),
   .rsp_toggle_flags  (rsp_toggle_flags)
);
